[rtl/core/htlu_pkg.sv]
// ----------------------------------------------------------------------------
// htlu_pkg
// Types, constants and the byte hash step shared by the hash tree leaf update
// logic.
// ----------------------------------------------------------------------------
package htlu_pkg;

	localparam int IDX_W  = 10;
	localparam int HASH_W = 64;
	localparam int CNT_W  = 11;
	localparam int HALF_W = 32;

	localparam logic [HALF_W-1:0] SEED_LEFT  = 32'h811c9dc5;
	localparam logic [HALF_W-1:0] SEED_RIGHT = 32'h174b2c15;
	localparam logic [HALF_W-1:0] HASH_PRIME = 32'h01000193;

	localparam logic [CNT_W-1:0] LEAF_COUNT_RST = 11'd1024;

	typedef logic [2:0] state_t;

	localparam state_t ST_IDLE  = 3'd0;
	localparam state_t ST_CLEAR = 3'd1;
	localparam state_t ST_LOAD  = 3'd2;
	localparam state_t ST_ROOT  = 3'd3;
	localparam state_t ST_RD    = 3'd4;
	localparam state_t ST_MIX   = 3'd5;
	localparam state_t ST_HASH  = 3'd6;
	localparam state_t ST_WB    = 3'd7;
	// ST_DONE shares no code slot; it is carried by done_q in the top level

	typedef logic [HALF_W-1:0] half_t;
	typedef logic [HASH_W-1:0] node_t;

	// one byte of the FNV-1a style hash: xor the byte in, multiply by the prime
	function automatic half_t hash_step(input half_t h, input logic [7:0] b);
		half_t x;
		x = h ^ {24'h0, b};
		return x * HASH_PRIME;
	endfunction

endpackage

[rtl/core/hash_tree_leaf_update_unit.sv]
// ----------------------------------------------------------------------------
// hash_tree_leaf_update_unit
// Binary hash tree of 64-bit nodes in heap order, held in one synchronous RAM;
// each in-range request overwrites a leaf and rehashes its ancestors to the root.
// ----------------------------------------------------------------------------
// Per level: sibling read, mux, one hash step per byte of each child, then
//   write-back of the parent, from the leaf's parent up to the root.
// Input: the next request is taken once the last result has moved into the
//   output register; a rejected index returns the root flagged, writing nothing.
// Reset: async, clears control state; a pass over the 2*P_MAX-1 nodes (2047 by
//   default) zeroes the RAM after reset and each leaf_count write, s_tready low.
module hash_tree_leaf_update_unit
	import htlu_pkg::*;
#(
	parameter int MAX_LEAVES = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	// config write: leaf_count
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CNT_W-1:0]  cfg_data,
	// s_tdata: [9:0] leaf_index, [73:10] leaf_hash, [79:74] zero
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [79:0]       s_tdata,
	// m_tdata: [63:0] root_hash
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [HASH_W-1:0] m_tdata,
	// m_tuser: [0] index_rejected
	output logic              m_tuser
);

	localparam int PMAX_RAW = 1 << $clog2(MAX_LEAVES);
	localparam int PMAX     = (PMAX_RAW > 2048) ? 2048 : PMAX_RAW;
	localparam int LW       = $clog2(PMAX);
	localparam int NODES    = 2 * PMAX - 1;
	localparam int AW       = LW + 1;
	localparam int PW       = 12;
	localparam int NW       = 17;

	localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);

	state_t             state_q;
	logic               done_q;
	logic [CNT_W-1:0]   leaf_count_q;
	logic [PW-1:0]      p_q;
	logic [PW-1:0]      p_next;
	logic [NW-1:0]      n_sat;
	logic [IDX_W-1:0]   idx_q;
	node_t              cur_q;
	logic [AW-1:0]      node_q;
	logic [AW-1:0]      clr_q;
	node_t              lw_q;
	node_t              rw_q;
	half_t              hl_q;
	half_t              hh_q;
	logic [2:0]         step_q;
	logic               rej_q;
	logic               out_vld_q;
	node_t              out_hash_q;
	logic               out_rej_q;

	logic               reject;
	logic [PW-1:0]      leaf_node_w;
	logic [AW-1:0]      leaf_node;
	logic [AW-1:0]      parent;
	logic [AW-1:0]      sibling;
	logic               out_free;

	node_t              mem [NODES];
	node_t              rd_q;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	node_t              wr_data;
	logic               rd_en;
	logic [AW-1:0]      rd_addr;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE) && !done_q;
	assign m_tvalid  = out_vld_q;
	assign m_tdata   = out_hash_q;
	assign m_tuser   = out_rej_q;

	// rounded leaf count: zero reads as one, saturate at MAX_LEAVES
	always_comb begin
		n_sat = (leaf_count_q == '0) ? NW'(1) : NW'(leaf_count_q);
		if (n_sat > NW'(MAX_LEAVES)) begin
			n_sat = NW'(MAX_LEAVES);
		end
		p_next = PW'(PMAX);
		for (int k = LW; k >= 0; k--) begin
			if ((NW'(1) << k) >= n_sat) begin
				p_next = PW'(1 << k);
			end
		end
	end

	assign reject      = PW'(idx_q) >= p_q;
	assign leaf_node_w = p_q - PW'(1) + PW'(idx_q);
	assign leaf_node   = leaf_node_w[AW-1:0];
	assign parent      = (node_q - AW'(1)) >> 1;
	assign sibling     = node_q[0] ? node_q + AW'(1) : node_q - AW'(1);
	assign out_free    = !out_vld_q || m_tready;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		rd_en   = 1'b0;
		rd_addr = '0;
		if (!done_q) begin
			unique case (state_q)
				ST_CLEAR: begin
					wr_en = 1'b1;
				end
				ST_LOAD: begin
					if (reject) begin
						rd_en = 1'b1;
					end else begin
						wr_en   = 1'b1;
						wr_addr = leaf_node;
						wr_data = cur_q;
					end
				end
				ST_RD: begin
					rd_en   = 1'b1;
					rd_addr = sibling;
				end
				ST_WB: begin
					wr_en   = 1'b1;
					wr_addr = parent;
					wr_data = {hh_q, hl_q};
				end
				default: begin
				end
			endcase
		end
	end

	// node RAM, one write and one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			done_q       <= 1'b0;
			leaf_count_q <= LEAF_COUNT_RST;
			p_q          <= '0;
			clr_q        <= '0;
			step_q       <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			p_q <= p_next;
			// a finished result taking the slot keeps it valid
			if (out_vld_q && m_tready && (cfg_valid || !done_q)) begin
				out_vld_q <= 1'b0;
			end
			if (cfg_valid) begin
				leaf_count_q <= cfg_data;
				state_q      <= ST_CLEAR;
				done_q       <= 1'b0;
				clr_q        <= '0;
			end else if (done_q) begin
				if (out_free) begin
					out_vld_q <= 1'b1;
					done_q    <= 1'b0;
					state_q   <= ST_IDLE;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (s_tvalid) begin
							state_q <= ST_LOAD;
						end
					end
					ST_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == LAST_NODE) begin
							state_q <= ST_IDLE;
						end
					end
					ST_LOAD: begin
						if (reject) begin
							state_q <= ST_ROOT;
						end else if (leaf_node == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RD;
						end
					end
					ST_ROOT: begin
						done_q <= 1'b1;
					end
					ST_RD: begin
						state_q <= ST_MIX;
					end
					ST_MIX: begin
						step_q  <= '0;
						state_q <= ST_HASH;
					end
					ST_HASH: begin
						step_q <= step_q + 3'd1;
						if (step_q == 3'd7) begin
							state_q <= ST_WB;
						end
					end
					ST_WB: begin
						if (parent == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_RD;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			idx_q <= s_tdata[IDX_W-1:0];
			cur_q <= s_tdata[IDX_W +: HASH_W];
		end
		if (done_q && out_free) begin
			out_hash_q <= cur_q;
			out_rej_q  <= rej_q;
		end
		if (!done_q) begin
			unique case (state_q)
				ST_LOAD: begin
					rej_q  <= reject;
					node_q <= leaf_node;
				end
				ST_ROOT: begin
					cur_q <= rd_q;
				end
				ST_MIX: begin
					// odd node is a left child
					lw_q <= node_q[0] ? cur_q : rd_q;
					rw_q <= node_q[0] ? rd_q : cur_q;
					hl_q <= SEED_LEFT;
					hh_q <= SEED_RIGHT;
				end
				ST_HASH: begin
					hl_q <= hash_step(hl_q, lw_q[7:0]);
					hh_q <= hash_step(hh_q, rw_q[7:0]);
					lw_q <= lw_q >> 8;
					rw_q <= rw_q >> 8;
				end
				ST_WB: begin
					cur_q  <= {hh_q, hl_q};
					node_q <= parent;
				end
				default: begin
				end
			endcase
		end
	end

	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |=> (state_q == ST_CLEAR) && !done_q && (clr_q == '0))
		else $error("leaf_count write did not restart the clearing pass");

	a_reject_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) && !done_q |-> !wr_en && rej_q)
		else $error("rejected request touched the node RAM");

	a_climb: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WB) && !done_q && !cfg_valid |=> node_q < $past(node_q))
		else $error("write-back did not move towards the root");

	a_accept_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !cfg_valid |=> (state_q == ST_LOAD) && !done_q)
		else $error("accepted request did not enter the load step");

	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && out_vld_q && !m_tready && !cfg_valid |=> done_q && $stable(cur_q))
		else $error("finished result lost while output register busy");

endmodule

[verif/tb_hash_tree_leaf_update_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hash_tree_leaf_update_unit
// Drives leaf writes through the stream slave port, rebuilds the hash tree in
// a local model and checks every root and reject flag in order. Walks several
// leaf counts, from a single-leaf tree to a saturated one, with random stalls in most phases.
// ----------------------------------------------------------------------------
module tb_hash_tree_leaf_update_unit;
	import htlu_pkg::*;

	localparam int CLK_HALF   = 5;
	localparam int LIMIT      = 1000000;
	localparam int MAX_SPAN   = 1024;
	localparam int NODE_COUNT = 2 * MAX_SPAN - 1;
	localparam int TAIL       = 150;
	localparam int PRINT_CAP  = 50;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		node_t            value;
	} leaf_write_t;

	typedef struct packed {
		node_t root;
		logic  rejected;
	} root_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CNT_W-1:0]  cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [79:0]       s_tdata = '0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [HASH_W-1:0] m_tdata;
	logic              m_tuser;

	hash_tree_leaf_update_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #CLK_HALF clk = ~clk;

	// local copy of the tree and its leaf count
	node_t        tree_nodes [0:NODE_COUNT-1];
	int unsigned  tree_span;
	leaf_write_t  leaf_writes [$];
	root_result_t expected_roots [$];
	int unsigned  leaves_queued;
	int unsigned  leaves_accepted;
	int unsigned  mismatch_count;
	int unsigned  cycle_count;
	bit           quiet;

	function automatic half_t fnv_fold(input half_t seed, input node_t word);
		half_t h;
		h = seed;
		for (int i = 0; i < 8; i++) begin
			h = (h ^ {24'h0, word[8*i +: 8]}) * HASH_PRIME;
		end
		return h;
	endfunction

	// zero is taken as one leaf, anything past the maximum saturates
	function automatic int unsigned span_of(input logic [CNT_W-1:0] count);
		int unsigned n;
		int unsigned p;
		n = (count == 0) ? 1 : count;
		if (n > MAX_SPAN)
			n = MAX_SPAN;
		p = 1;
		while (p < n)
			p = p << 1;
		return p;
	endfunction

	task automatic set_leaf_count(input logic [CNT_W-1:0] count);
		tree_span = span_of(count);
		foreach (tree_nodes[i])
			tree_nodes[i] = '0;
	endtask

	task automatic apply_leaf(input logic [IDX_W-1:0] index, input node_t value);
		int unsigned  node;
		int unsigned  parent;
		root_result_t r;
		if (index >= tree_span) begin
			r.rejected = 1'b1;
		end else begin
			node = tree_span - 1 + index;
			tree_nodes[node] = value;
			while (node > 0) begin
				parent = (node - 1) / 2;
				tree_nodes[parent] = {fnv_fold(SEED_RIGHT, tree_nodes[2*parent+2]),
					fnv_fold(SEED_LEFT, tree_nodes[2*parent+1])};
				node = parent;
			end
			r.rejected = 1'b0;
		end
		r.root = tree_nodes[0];
		expected_roots.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input node_t got, input node_t want);
		if (mismatch_count < PRINT_CAP)
			$display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	task automatic queue_leaf(input logic [IDX_W-1:0] index, input node_t value);
		leaf_write_t w;
		w.index = index;
		w.value = value;
		leaf_writes.push_back(w);
		leaves_queued++;
	endtask

	task automatic queue_random(input int unsigned count);
		logic [IDX_W-1:0] index;
		node_t            value;
		for (int unsigned i = 0; i < count; i++) begin
			// mostly indexes inside the tree; the odd one anywhere, which may be rejected
			if ($urandom_range(0, 7) == 0)
				index = IDX_W'($urandom_range(0, MAX_SPAN - 1));
			else
				index = IDX_W'($urandom_range(0, tree_span - 1));
			case ($urandom_range(0, 15))
				0:       value = '0;
				1:       value = '1;
				default: value = {$urandom, $urandom};
			endcase
			queue_leaf(index, value);
		end
	endtask

	task automatic wait_drained();
		while (leaves_accepted != leaves_queued || expected_roots.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_leaf_count(input logic [CNT_W-1:0] count);
		wait_drained();
		repeat (8) @(posedge clk);
		cfg_data  <= count;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		set_leaf_count(count);
	endtask

	// leaf request driver
	int unsigned send_gap = 0;
	always @(posedge clk) begin
		leaf_write_t w;
		if (s_tvalid && s_tready) begin
			apply_leaf(s_tdata[IDX_W-1:0], s_tdata[IDX_W +: HASH_W]);
			leaves_accepted++;
		end
		if (!s_tvalid || s_tready) begin
			if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (leaf_writes.size() > 0) begin
				w = leaf_writes.pop_front();
				s_tdata  <= {6'b0, w.value, w.index};
				s_tvalid <= 1'b1;
				send_gap = quiet ? 0 : $urandom_range(0, 15);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// root monitor; the stall only counts down while a result is on offer
	int unsigned rx_wait = 0;
	always @(posedge clk) begin
		root_result_t e;
		if (m_tvalid && m_tready) begin
			if (expected_roots.size() == 0) begin
				report_mismatch("unrequested root", m_tdata, '0);
			end else begin
				e = expected_roots.pop_front();
				if (m_tdata !== e.root)
					report_mismatch("root_hash", m_tdata, e.root);
				if (m_tuser !== e.rejected)
					report_mismatch("index_rejected", node_t'(m_tuser), node_t'(e.rejected));
			end
			rx_wait = quiet ? 0 : $urandom_range(0, 15);
		end else if (rx_wait > 0 && m_tvalid) begin
			rx_wait--;
		end
		m_tready <= (rx_wait == 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT) begin
			$display("tb_hash_tree_leaf_update_unit: FAIL");
			$finish;
		end
	end

	logic [CNT_W-1:0] phase_counts [10] = '{11'd1, 11'd0, 11'd2, 11'd3, 11'd6,
		11'd16, 11'd100, 11'd2047, 11'd513, 11'd255};
	int unsigned      phase_items  [10] = '{20, 15, 40, 40, 50, 50, 50, 40, 40, 45};

	initial begin
		set_leaf_count(LEAF_COUNT_RST);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// full-size tree out of reset: corners and bit patterns
		queue_leaf(10'd0, 64'h0);
		queue_leaf(10'd1023, '1);
		queue_leaf(10'd512, 64'haaaa_aaaa_aaaa_aaaa);
		queue_leaf(10'd511, 64'h5555_5555_5555_5555);
		queue_leaf(10'd0, 64'h0123_4567_89ab_cdef);
		queue_leaf(10'd1, 64'h8000_0000_0000_0001);
		queue_random(30);
		// hold off until the tree has caught up, then carry on
		wait_drained();
		queue_random(30);

		for (int ph = 0; ph < 10; ph++) begin
			write_leaf_count(phase_counts[ph]);
			quiet = (ph % 4 == 3);
			// last leaf of the span, and the first index past it where there is one
			queue_leaf(IDX_W'(tree_span - 1), {$urandom, $urandom});
			if (tree_span < MAX_SPAN)
				queue_leaf(IDX_W'(tree_span), {$urandom, $urandom});
			queue_random(phase_items[ph]);
		end

		wait_drained();
		repeat (TAIL) @(posedge clk);
		if (mismatch_count == 0 && expected_roots.size() == 0) begin
			$display("tb_hash_tree_leaf_update_unit: PASS");
		end else begin
			$display("tb_hash_tree_leaf_update_unit: FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/core/htlu_pkg.sv
rtl/core/hash_tree_leaf_update_unit.sv
verif/tb_hash_tree_leaf_update_unit.sv
